// ===== sv/rv32se_pkg.sv =====
// Shared types and constants for the RV32 subset execute unit.
package rv32se_pkg;

  localparam int XLEN      = 32;
  localparam int NUM_REGS  = 32;
  localparam int REG_AW    = $clog2(NUM_REGS);
  localparam int MEM_WORDS = 1024;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int BYTE_AW   = MEM_AW + 2;
  localparam int IMM_W     = 12;

  typedef enum logic [2:0] {
    OP_LW   = 3'd0,
    OP_SW   = 3'd1,
    OP_ADD  = 3'd2,
    OP_ADDI = 3'd3,
    OP_AND  = 3'd4,
    OP_OR   = 3'd5,
    OP_XOR  = 3'd6,
    OP_INV  = 3'd7
  } op_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] idx;
    logic [XLEN-1:0]   data;
  } rf_wb_t;

  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [MEM_AW-1:0] word;
    logic [XLEN-1:0]   data;
  } dmem_req_t;

  typedef struct packed {
    logic               op_valid;
    logic               reg_wr;
    logic [REG_AW-1:0]  widx;
    logic               is_load;
    logic               is_store;
    logic [XLEN-1:0]    result;
    logic [BYTE_AW-1:0] byte_addr;
  } exec_t;

endpackage

// ===== sv/rv32se_regfile.sv =====
// Register file with reset-to-index valid bits, registered reads and write bypass.
module rv32se_regfile
  import rv32se_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [REG_AW-1:0] rd_addr1,
  input  logic [REG_AW-1:0] rd_addr2,
  input  rf_wb_t            wb,
  output logic [XLEN-1:0]   rd_data1,
  output logic [XLEN-1:0]   rd_data2
);

  logic [XLEN-1:0]     rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [XLEN-1:0]     raw1_r;
  logic [XLEN-1:0]     raw2_r;
  logic                vld1_r;
  logic                vld2_r;
  logic                byp1_r;
  logic                byp2_r;
  logic [REG_AW-1:0]   idx1_r;
  logic [REG_AW-1:0]   idx2_r;
  logic [XLEN-1:0]     bdata_r;

  always_ff @(posedge clk) begin
    if (wb.en) begin
      rf_mem[wb.idx] <= wb.data;
    end
    if (rd_en) begin
      raw1_r  <= rf_mem[rd_addr1];
      raw2_r  <= rf_mem[rd_addr2];
      vld1_r  <= vld_r[rd_addr1];
      vld2_r  <= vld_r[rd_addr2];
      byp1_r  <= wb.en && (wb.idx == rd_addr1);
      byp2_r  <= wb.en && (wb.idx == rd_addr2);
      idx1_r  <= rd_addr1;
      idx2_r  <= rd_addr2;
      bdata_r <= wb.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wb.en) begin
      vld_r[wb.idx] <= 1'b1;
    end
  end

  always_comb begin
    if (byp1_r) begin
      rd_data1 = bdata_r;
    end else if (vld1_r) begin
      rd_data1 = raw1_r;
    end else begin
      rd_data1 = {{(XLEN-REG_AW){1'b0}}, idx1_r};
    end
    if (byp2_r) begin
      rd_data2 = bdata_r;
    end else if (vld2_r) begin
      rd_data2 = raw2_r;
    end else begin
      rd_data2 = {{(XLEN-REG_AW){1'b0}}, idx2_r};
    end
  end

endmodule

// ===== sv/rv32se_dmem.sv =====
// Word data memory with a clearing pass after reset and registered read data.
module rv32se_dmem
  import rv32se_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  dmem_req_t       req,
  output logic            busy,
  output logic [XLEN-1:0] rd_data
);

  logic [XLEN-1:0]   dmem [MEM_WORDS];
  logic              busy_r;
  logic              busy_nxt;
  logic [MEM_AW-1:0] ptr_r;
  logic [MEM_AW-1:0] ptr_nxt;
  logic [XLEN-1:0]   rdata_r;
  logic              we;
  logic [MEM_AW-1:0] waddr;
  logic [XLEN-1:0]   wdata;

  always_comb begin
    busy_nxt = busy_r;
    ptr_nxt  = ptr_r;
    if (busy_r) begin
      ptr_nxt = ptr_r + 1'b1;
      if (ptr_r == MEM_AW'(MEM_WORDS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      ptr_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ptr_r  <= ptr_nxt;
    end
  end

  assign we    = busy_r || req.wr;
  assign waddr = busy_r ? ptr_r : req.word;
  assign wdata = busy_r ? '0 : req.data;

  always_ff @(posedge clk) begin
    if (we) begin
      dmem[waddr] <= wdata;
    end
    if (req.rd) begin
      rdata_r <= dmem[req.word];
    end
  end

  assign busy    = busy_r;
  assign rd_data = rdata_r;

endmodule

// ===== sv/rv32se_alu.sv =====
// Decode, ALU and effective address logic for one instruction.
module rv32se_alu
  import rv32se_pkg::*;
(
  input  logic [2:0]        op,
  input  logic [REG_AW-1:0] rd,
  input  logic [XLEN-1:0]   a,
  input  logic [XLEN-1:0]   b,
  input  logic [IMM_W-1:0]  imm,
  output exec_t             ex
);

  logic [XLEN-1:0] imm_ext;
  logic [XLEN-1:0] imm_sum;
  logic [XLEN-1:0] reg_sum;
  logic            rd_nz;

  assign imm_ext = {{(XLEN-IMM_W){imm[IMM_W-1]}}, imm};
  assign imm_sum = a + imm_ext;
  assign reg_sum = a + b;
  assign rd_nz   = (rd != '0);

  always_comb begin
    ex = '0;
    case (op_t'(op))
      OP_LW: begin
        ex.op_valid  = 1'b1;
        ex.reg_wr    = rd_nz;
        ex.widx      = rd;
        ex.is_load   = 1'b1;
        ex.byte_addr = imm_sum[BYTE_AW-1:0];
      end
      OP_SW: begin
        ex.op_valid  = 1'b1;
        ex.is_store  = 1'b1;
        ex.result    = b;
        ex.byte_addr = imm_sum[BYTE_AW-1:0];
      end
      OP_ADD: begin
        ex.op_valid = 1'b1;
        ex.reg_wr   = rd_nz;
        ex.widx     = rd;
        ex.result   = reg_sum;
      end
      OP_ADDI: begin
        ex.op_valid = 1'b1;
        ex.reg_wr   = rd_nz;
        ex.widx     = rd;
        ex.result   = imm_sum;
      end
      OP_AND: begin
        ex.op_valid = 1'b1;
        ex.reg_wr   = rd_nz;
        ex.widx     = rd;
        ex.result   = a & b;
      end
      OP_OR: begin
        ex.op_valid = 1'b1;
        ex.reg_wr   = rd_nz;
        ex.widx     = rd;
        ex.result   = a | b;
      end
      OP_XOR: begin
        ex.op_valid = 1'b1;
        ex.reg_wr   = rd_nz;
        ex.widx     = rd;
        ex.result   = a ^ b;
      end
      default: begin
        ex = '0;
      end
    endcase
  end

endmodule

// ===== sv/rv32_subset_execute_unit.sv =====
// Top level of the RV32 subset execute unit (LW, SW, ADD, ADDI, AND, OR, XOR).
//
// Usage: one decoded instruction enters on the in_ channel, one result item
// leaves on the out_ channel for every instruction, in order. An item moves
// when valid is high and stall is low at a rising clock edge.
// Pipeline: an accepted item enters stage one and then moves to stage two,
// where out_valid is high and the result can be taken. Stage one holds the
// registered register file read and does ALU, address and store; stage two
// holds the result and the registered data memory read for loads.
// Throughput: one item per cycle while out_stall is low; register results are
// forwarded from stage two, so dependent instructions follow back to back.
// Reset: synchronous, active low. Registers read as their own index until
// written. The data memory is then cleared, all 1024 words, one word per cycle,
// with in_stall high throughout.
// Stall: when out_stall holds a result, stage two freezes and an empty stage
// one can still take an item; in_stall rises only once stage one is also occupied.
module rv32_subset_execute_unit
  import rv32se_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_req_type,
  input  logic [4:0]                in_dest_index,
  input  logic [4:0]                in_src1_index,
  input  logic [4:0]                in_src2_index,
  input  logic signed [11:0]        in_immediate,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_op_valid,
  output logic                      out_reg_written,
  output logic [4:0]                out_written_index,
  output logic signed [31:0]        out_result_value,
  output logic [11:0]               out_mem_byte_address
);

  logic               en;
  logic               in_acc;
  logic               clr_busy;

  logic               s1_vld_r;
  logic [2:0]         s1_op_r;
  logic [REG_AW-1:0]  s1_rd_r;
  logic [REG_AW-1:0]  s1_rs1_r;
  logic [REG_AW-1:0]  s1_rs2_r;
  logic [IMM_W-1:0]   s1_imm_r;

  logic               s2_vld_r;
  logic               s2_opv_r;
  logic               s2_wr_r;
  logic [REG_AW-1:0]  s2_widx_r;
  logic               s2_load_r;
  logic [XLEN-1:0]    s2_res_r;
  logic [BYTE_AW-1:0] s2_addr_r;

  logic [XLEN-1:0]    rf_a;
  logic [XLEN-1:0]    rf_b;
  logic [XLEN-1:0]    op_a;
  logic [XLEN-1:0]    op_b;
  logic [XLEN-1:0]    s2_val;
  logic [XLEN-1:0]    mem_rdata;
  rf_wb_t             wb;
  dmem_req_t          mreq;
  exec_t              ex;

  assign en       = !s2_vld_r || !out_stall;
  assign in_stall = !rst_n || clr_busy || (s1_vld_r && !en);
  assign in_acc   = in_valid && !in_stall;

  assign s2_val  = s2_load_r ? mem_rdata : s2_res_r;
  assign wb.en   = s2_vld_r && !out_stall && s2_wr_r;
  assign wb.idx  = s2_widx_r;
  assign wb.data = s2_val;

  rv32se_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr1 (in_src1_index),
    .rd_addr2 (in_src2_index),
    .wb       (wb),
    .rd_data1 (rf_a),
    .rd_data2 (rf_b)
  );

  assign op_a = (s2_vld_r && s2_wr_r && (s2_widx_r == s1_rs1_r)) ? s2_val : rf_a;
  assign op_b = (s2_vld_r && s2_wr_r && (s2_widx_r == s1_rs2_r)) ? s2_val : rf_b;

  rv32se_alu u_alu (
    .op  (s1_op_r),
    .rd  (s1_rd_r),
    .a   (op_a),
    .b   (op_b),
    .imm (s1_imm_r),
    .ex  (ex)
  );

  assign mreq.wr   = en && s1_vld_r && ex.is_store;
  assign mreq.rd   = en && s1_vld_r && ex.is_load;
  assign mreq.word = ex.byte_addr[BYTE_AW-1:2];
  assign mreq.data = op_b;

  rv32se_dmem u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .busy    (clr_busy),
    .rd_data (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (en || !s1_vld_r) begin
        s1_vld_r <= in_acc;
      end
      if (en) begin
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_req_type;
      s1_rd_r  <= in_dest_index;
      s1_rs1_r <= in_src1_index;
      s1_rs2_r <= in_src2_index;
      s1_imm_r <= in_immediate;
    end
    if (en && s1_vld_r) begin
      s2_opv_r  <= ex.op_valid;
      s2_wr_r   <= ex.reg_wr;
      s2_widx_r <= ex.widx;
      s2_load_r <= ex.is_load;
      s2_res_r  <= ex.result;
      s2_addr_r <= ex.byte_addr;
    end
  end

  assign out_valid            = s2_vld_r;
  assign out_op_valid         = s2_opv_r;
  assign out_reg_written      = s2_wr_r;
  assign out_written_index    = s2_widx_r;
  assign out_result_value     = s2_val;
  assign out_mem_byte_address = s2_addr_r;

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clr_busy |-> in_stall
  ) else $error("input accepted during memory clear");

  a_written_index_nonzero: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_valid && out_reg_written) |-> (out_written_index != '0)
  ) else $error("register write reported for x0");

  a_invalid_result_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_valid && !out_op_valid) |->
        (!out_reg_written && (out_written_index == '0) &&
         (out_result_value == '0) && (out_mem_byte_address == '0))
  ) else $error("invalid opcode produced nonzero result");

  a_rf_write_only_on_delivery: assert property (
    @(posedge clk) disable iff (!rst_n)
      wb.en |-> (out_valid && !out_stall && out_reg_written)
  ) else $error("register write without delivered result");

endmodule

// ===== tb/sv/tb_rv32_subset_execute_unit.sv =====
// Testbench for rv32_subset_execute_unit: directed and random streams checked against a model.
module tb_rv32_subset_execute_unit;
  import rv32se_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CHUNK        = 100;

  typedef struct packed {
    logic        op_valid;
    logic        reg_written;
    logic [4:0]  widx;
    logic [31:0] value;
    logic [11:0] addr;
  } retire_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_req_type;
  logic [4:0]         in_dest_index;
  logic [4:0]         in_src1_index;
  logic [4:0]         in_src2_index;
  logic signed [11:0] in_immediate;
  logic               out_valid;
  logic               out_stall;
  logic               out_op_valid;
  logic               out_reg_written;
  logic [4:0]         out_written_index;
  logic signed [31:0] out_result_value;
  logic [11:0]        out_mem_byte_address;

  logic [31:0] gpr_model [NUM_REGS];
  logic [31:0] dmem_model [MEM_WORDS];
  retire_t     retire_q [$];
  int          fail_count;
  int          idle_cycles;
  int          hold_off_cycles;
  bit          send_idle_en;
  bit          recv_idle_en;

  rv32_subset_execute_unit u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_dest_index        (in_dest_index),
    .in_src1_index        (in_src1_index),
    .in_src2_index        (in_src2_index),
    .in_immediate         (in_immediate),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_op_valid         (out_op_valid),
    .out_reg_written      (out_reg_written),
    .out_written_index    (out_written_index),
    .out_result_value     (out_result_value),
    .out_mem_byte_address (out_mem_byte_address)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic retire_t execute_model(op_t op, logic [4:0] rd, logic [4:0] rs1,
                                            logic [4:0] rs2, logic [11:0] imm);
    retire_t     r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] simm;
    int unsigned span;
    int unsigned ea;
    logic        wb;
    a    = (rs1 == 5'd0) ? 32'd0 : gpr_model[rs1];
    b    = (rs2 == 5'd0) ? 32'd0 : gpr_model[rs2];
    simm = {{20{imm[11]}}, imm};
    span = 4 * MEM_WORDS;
    r    = '0;
    r.op_valid = 1'b1;
    wb   = 1'b1;
    case (op)
      OP_LW, OP_SW: begin
        ea     = 32'(a + simm) % span;
        r.addr = ea[11:0];
        if (op == OP_LW) begin
          r.value = dmem_model[ea >> 2];
        end else begin
          r.value = b;
          dmem_model[ea >> 2] = b;
          wb = 1'b0;
        end
      end
      OP_ADD:  r.value = a + b;
      OP_ADDI: r.value = a + simm;
      OP_AND:  r.value = a & b;
      OP_OR:   r.value = a | b;
      OP_XOR:  r.value = a ^ b;
      default: begin
        r.op_valid = 1'b0;
        wb = 1'b0;
      end
    endcase
    if (wb) begin
      r.widx        = rd;
      r.reg_written = (rd != 5'd0);
      if (rd != 5'd0) gpr_model[rd] = r.value;
    end
    return r;
  endfunction

  task automatic send_item(op_t op, logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2,
                           logic [11:0] imm);
    int unsigned gap;
    gap = send_idle_en ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= op;
    in_dest_index <= rd;
    in_src1_index <= rs1;
    in_src2_index <= rs2;
    in_immediate  <= imm;
    do @(posedge clk); while (in_stall);
    retire_q.push_back(execute_model(op, rd, rs1, rs2, imm));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (retire_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    op_t         op;
    logic [4:0]  rs1;
    logic [11:0] imm;
    pick = $urandom_range(0, 99);
    if (pick < 5)       op = OP_INV;
    else if (pick < 25) op = OP_LW;
    else if (pick < 45) op = OP_SW;
    else                op = op_t'($urandom_range(OP_ADD, OP_XOR));
    rs1 = 5'($urandom_range(0, 31));
    imm = 12'($urandom_range(0, 4095));
    // keep half the memory traffic in a small window so loads see stored data
    if ((op == OP_LW || op == OP_SW) && $urandom_range(0, 1) == 0) begin
      rs1 = 5'd0;
      imm = 12'($urandom_range(0, 63) * 4 + $urandom_range(0, 3));
    end
    send_item(op, 5'($urandom_range(0, 31)), rs1, 5'($urandom_range(0, 31)), imm);
  endtask

  task automatic test_alu_extremes();
    send_item(OP_ADDI, 5'd5, 5'd0, 5'd0, 12'h7FF);
    send_item(OP_ADDI, 5'd6, 5'd31, 5'd0, 12'h800);
    send_item(OP_ADD, 5'd7, 5'd5, 5'd6, 12'h000);
    send_item(OP_AND, 5'd8, 5'd31, 5'd7, 12'hFFF);
    send_item(OP_OR, 5'd9, 5'd8, 5'd30, 12'h000);
    send_item(OP_XOR, 5'd10, 5'd9, 5'd7, 12'h555);
  endtask

  task automatic test_x0_destination();
    send_item(OP_XOR, 5'd0, 5'd31, 5'd29, 12'h000);
    send_item(OP_ADDI, 5'd0, 5'd31, 5'd0, 12'h005);
    send_item(OP_ADD, 5'd11, 5'd0, 5'd0, 12'h000);
  endtask

  task automatic test_load_store();
    send_item(OP_SW, 5'd31, 5'd6, 5'd7, 12'hFFC);
    send_item(OP_LW, 5'd12, 5'd6, 5'd0, 12'hFFC);
    send_item(OP_LW, 5'd0, 5'd6, 5'd0, 12'hFFC);
    send_item(OP_SW, 5'd1, 5'd0, 5'd31, 12'h7FF);
    send_item(OP_LW, 5'd13, 5'd0, 5'd0, 12'h7FC);
    send_item(OP_SW, 5'd0, 5'd5, 5'd0, 12'h000);
  endtask

  task automatic test_invalid_opcode();
    send_item(OP_INV, 5'd31, 5'd31, 5'd31, 12'hFFF);
    send_item(OP_INV, 5'd0, 5'd0, 5'd0, 12'h000);
  endtask

  task automatic test_forwarding();
    send_item(OP_ADD, 5'd31, 5'd31, 5'd31, 12'h000);
    send_item(OP_ADD, 5'd31, 5'd31, 5'd31, 12'h000);
    send_item(OP_LW, 5'd14, 5'd0, 5'd0, 12'h7FC);
    send_item(OP_SW, 5'd2, 5'd14, 5'd14, 12'h000);
  endtask

  task automatic test_receiver_holdoff();
    send_idle_en    = 1'b0;
    hold_off_cycles = 250;
    repeat (40) send_random_item();
    wait_drained();
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % CHUNK == 0) begin
        send_idle_en = ($urandom_range(0, 3) != 0);
        recv_idle_en = ($urandom_range(0, 3) != 0);
        if (n % (4 * CHUNK) == 0) wait_drained();
      end
      send_random_item();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    retire_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (retire_q.size() == 0) begin
        $error("result with no pending instruction");
        fail_count++;
      end else begin
        want = retire_q.pop_front();
        if (out_op_valid !== want.op_valid) begin
          $error("op_valid: expected %0d, got %0d", want.op_valid, out_op_valid);
          fail_count++;
        end
        if (out_reg_written !== want.reg_written) begin
          $error("reg_written: expected %0d, got %0d", want.reg_written, out_reg_written);
          fail_count++;
        end
        if (out_written_index !== want.widx) begin
          $error("written_index: expected %0d, got %0d", want.widx, out_written_index);
          fail_count++;
        end
        if (out_result_value !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, out_result_value);
          fail_count++;
        end
        if (out_mem_byte_address !== want.addr) begin
          $error("mem_byte_address: expected %h, got %h", want.addr, out_mem_byte_address);
          fail_count++;
        end
      end
    end
  end

  // result receiver
  initial begin
    int unsigned wait_n;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      wait_n = recv_idle_en ? $urandom_range(0, 14) : 0;
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** rv32_subset_execute_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= OP_INV;
    in_dest_index <= '0;
    in_src1_index <= '0;
    in_src2_index <= '0;
    in_immediate  <= '0;
    fail_count      = 0;
    idle_cycles     = 0;
    hold_off_cycles = 0;
    send_idle_en    = 1'b1;
    recv_idle_en    = 1'b1;
    for (int i = 0; i < NUM_REGS; i++) gpr_model[i] = 32'(i);
    gpr_model[0] = '0;
    for (int i = 0; i < MEM_WORDS; i++) dmem_model[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_alu_extremes();
    test_x0_destination();
    test_load_store();
    test_invalid_opcode();
    test_forwarding();
    wait_drained();
    test_receiver_holdoff();
    test_random_mix();
    wait_drained();
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("** rv32_subset_execute_unit: PASSED **");
    end else begin
      $display("** rv32_subset_execute_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rv32se_pkg.sv
sv/rv32se_regfile.sv
sv/rv32se_dmem.sv
sv/rv32se_alu.sv
sv/rv32_subset_execute_unit.sv
tb/sv/tb_rv32_subset_execute_unit.sv
